### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/core/cmplt_pkg.sv
// ----------------------------------------------------------------------------
// cmplt_pkg
// Types, codes and step functions of the cache-miss path latency tracker.
// ----------------------------------------------------------------------------
package cmplt_pkg;

   // Table geometry and field widths.
   localparam int ID_SLOTS    = 256;
   localparam int IDX_W       = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
   localparam int TICK_W      = 48;
   localparam int COUNT_W     = 32;
   localparam int TOTAL_W     = 64;
   localparam int NUM_CLASSES = 5;
   localparam int CLASS_W     = 3;

   // Word modes.
   localparam logic [1:0] MODE_EVENT  = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Cache event codes.
   localparam logic [3:0] EV_L1_LD_MISS  = 4'd0;
   localparam logic [3:0] EV_L1_ST_MISS  = 4'd1;
   localparam logic [3:0] EV_L1_FINISH   = 4'd2;
   localparam logic [3:0] EV_L1_TRANSMIT = 4'd3;
   localparam logic [3:0] EV_L2_HIT      = 4'd4;
   localparam logic [3:0] EV_L2_MISS     = 4'd5;
   localparam logic [3:0] EV_L2_FWD      = 4'd6;
   localparam logic [3:0] EV_L2_TRANSMIT = 4'd7;
   localparam logic [3:0] EV_L2_FINISH   = 4'd8;
   localparam logic [3:0] EV_L3_HIT      = 4'd9;
   localparam logic [3:0] EV_L3_MISS     = 4'd10;
   localparam logic [3:0] EV_L3_FWD      = 4'd11;
   localparam logic [3:0] EV_MEM         = 4'd12;

   // Path steps of an open entry.
   localparam logic [3:0] PS_NONE    = 4'd0;
   localparam logic [3:0] PS_MISS    = 4'd1;
   localparam logic [3:0] PS_L2H     = 4'd2;
   localparam logic [3:0] PS_L2F     = 4'd3;
   localparam logic [3:0] PS_L2F_T   = 4'd4;
   localparam logic [3:0] PS_L2M     = 4'd5;
   localparam logic [3:0] PS_L3H     = 4'd6;
   localparam logic [3:0] PS_L3H_F   = 4'd7;
   localparam logic [3:0] PS_L3F     = 4'd8;
   localparam logic [3:0] PS_L3F_T   = 4'd9;
   localparam logic [3:0] PS_L3F_T_F = 4'd10;
   localparam logic [3:0] PS_L3M     = 4'd11;
   localparam logic [3:0] PS_MEM     = 4'd12;
   localparam logic [3:0] PS_MEM_F   = 4'd13;

   // Path classes.
   localparam logic [CLASS_W-1:0] CLS_L2_HIT = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_L2_FWD = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_L3_HIT = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_L3_FWD = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_MEM    = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd5;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        txn_id;
      logic [3:0]        event_code;
      logic [TICK_W-1:0] now_tick;
   } req_word_type;

   typedef struct packed {
      logic               completed;
      logic [CLASS_W-1:0] path_class;
      logic [TICK_W-1:0]  path_latency;
      logic [COUNT_W-1:0] class_count;
      logic [TOTAL_W-1:0] class_tick_total;
   } rsp_word_type;

   // One row of the transaction table.
   typedef struct packed {
      logic [3:0]        path_state;
      logic [TICK_W-1:0] last_tick;
      logic [TICK_W-1:0] latency_sum;
   } entry_type;

   // What the entry stage hands to the statistics stage.
   typedef struct packed {
      logic               clear;
      logic               completed;
      logic [CLASS_W-1:0] path_class;
      logic [TICK_W-1:0]  path_latency;
   } hop_word_type;

   // Next path step for a non-finish event, PS_NONE when it does not match.
   function automatic logic [3:0] next_step(input logic [3:0] st, input logic [3:0] ev);
      logic [3:0] nx;
      nx = PS_NONE;
      unique case (st)
         PS_MISS: begin
            if (ev == EV_L2_HIT)       nx = PS_L2H;
            else if (ev == EV_L2_FWD)  nx = PS_L2F;
            else if (ev == EV_L2_MISS) nx = PS_L2M;
         end
         PS_L2F:   if (ev == EV_L1_TRANSMIT) nx = PS_L2F_T;
         PS_L2M: begin
            if (ev == EV_L3_HIT)       nx = PS_L3H;
            else if (ev == EV_L3_FWD)  nx = PS_L3F;
            else if (ev == EV_L3_MISS) nx = PS_L3M;
         end
         PS_L3H:   if (ev == EV_L2_FINISH) nx = PS_L3H_F;
         PS_L3F:   if (ev == EV_L2_TRANSMIT) nx = PS_L3F_T;
         PS_L3F_T: if (ev == EV_L2_FINISH) nx = PS_L3F_T_F;
         PS_L3M:   if (ev == EV_MEM) nx = PS_MEM;
         PS_MEM:   if (ev == EV_L2_FINISH) nx = PS_MEM_F;
         default:  nx = PS_NONE;
      endcase
      return nx;
   endfunction

   // Class of a finishing step, CLS_NONE when the path is not complete.
   function automatic logic [CLASS_W-1:0] finish_class(input logic [3:0] st);
      logic [CLASS_W-1:0] c;
      unique case (st)
         PS_L2H:     c = CLS_L2_HIT;
         PS_L2F_T:   c = CLS_L2_FWD;
         PS_L3H_F:   c = CLS_L3_HIT;
         PS_L3F_T_F: c = CLS_L3_FWD;
         PS_MEM_F:   c = CLS_MEM;
         default:    c = CLS_NONE;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/cmplt_entry_stage.sv
// ----------------------------------------------------------------------------
// cmplt_entry_stage
// Transaction table with open bits; one read-modify-write per word.
// ----------------------------------------------------------------------------
module cmplt_entry_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   req_valid,
   input  cmplt_pkg::req_word_type req_word,
   output logic                   hop_valid,
   output cmplt_pkg::hop_word_type hop_word
);

   // Table storage; rows are written when an entry opens and when its path step advances.
   cmplt_pkg::entry_type ent_mem [cmplt_pkg::ID_SLOTS];
   logic [cmplt_pkg::ID_SLOTS-1:0] open_ff;

   logic                    s1_vld_ff;
   cmplt_pkg::req_word_type s1_req_ff;
   cmplt_pkg::entry_type    ent_rd_ff;
   cmplt_pkg::entry_type    byp_ent_ff;
   logic                    byp_hit_ff;
   logic                    hop_vld_ff;
   cmplt_pkg::hop_word_type hop_ff;

   logic [cmplt_pkg::IDX_W-1:0] req_idx;
   logic [cmplt_pkg::IDX_W-1:0] s1_idx;
   logic                        id_ok;
   logic                        is_open;
   cmplt_pkg::entry_type        ent_cur;
   logic [cmplt_pkg::TICK_W-1:0] diff;
   logic [cmplt_pkg::TICK_W-1:0] hop_ticks;
   logic [cmplt_pkg::TICK_W:0]   lat_sum;
   logic [cmplt_pkg::TICK_W-1:0] lat_new;
   logic [3:0]                   nx_step;
   logic [cmplt_pkg::CLASS_W-1:0] fin_cls;
   logic                        wr_en;
   cmplt_pkg::entry_type        wr_ent;
   logic                        open_set;
   logic                        open_clr;
   cmplt_pkg::hop_word_type     hop_in;

   assign req_idx = cmplt_pkg::IDX_W'(req_word.txn_id);
   assign s1_idx  = cmplt_pkg::IDX_W'(s1_req_ff.txn_id);
   assign id_ok   = (s1_req_ff.txn_id != 8'd0) &&
                    (32'(s1_req_ff.txn_id) < cmplt_pkg::ID_SLOTS);
   assign is_open = open_ff[s1_idx];

   // The row written by the previous word wins over the stale memory read.
   assign ent_cur = byp_hit_ff ? byp_ent_ff : ent_rd_ff;

   // Hop interval modulo the tick width, at least one, added with saturation.
   assign diff      = s1_req_ff.now_tick - ent_cur.last_tick;
   assign hop_ticks = (diff == '0) ? cmplt_pkg::TICK_W'(1) : diff;
   assign lat_sum   = {1'b0, ent_cur.latency_sum} + {1'b0, hop_ticks};
   assign lat_new   = lat_sum[cmplt_pkg::TICK_W] ? '1 : lat_sum[cmplt_pkg::TICK_W-1:0];

   assign nx_step = cmplt_pkg::next_step(ent_cur.path_state, s1_req_ff.event_code);
   assign fin_cls = cmplt_pkg::finish_class(ent_cur.path_state);

   // Decide the table update and the word for the statistics stage.
   always_comb begin
      wr_en                = 1'b0;
      wr_ent.path_state    = cmplt_pkg::PS_MISS;
      wr_ent.last_tick     = s1_req_ff.now_tick;
      wr_ent.latency_sum   = '0;
      open_set             = 1'b0;
      open_clr             = 1'b0;
      hop_in               = '0;
      hop_in.clear         = (s1_req_ff.mode == cmplt_pkg::MODE_CLEAR);
      if (s1_vld_ff && id_ok) begin
         priority if (s1_req_ff.mode == cmplt_pkg::MODE_CANCEL) begin
            open_clr = 1'b1;
         end else if (s1_req_ff.mode == cmplt_pkg::MODE_EVENT) begin
            priority if (!is_open) begin
               if (s1_req_ff.event_code == cmplt_pkg::EV_L1_LD_MISS ||
                   s1_req_ff.event_code == cmplt_pkg::EV_L1_ST_MISS) begin
                  open_set = 1'b1;
                  wr_en    = 1'b1;
               end
            end else if (s1_req_ff.event_code == cmplt_pkg::EV_L1_FINISH) begin
               open_clr = 1'b1;
               if (fin_cls != cmplt_pkg::CLS_NONE) begin
                  hop_in.completed    = 1'b1;
                  hop_in.path_class   = fin_cls;
                  hop_in.path_latency = lat_new;
               end
            end else if (nx_step != cmplt_pkg::PS_NONE) begin
               wr_en              = 1'b1;
               wr_ent.path_state  = nx_step;
               wr_ent.latency_sum = lat_new;
            end else begin
               wr_en = 1'b0;
            end
         end else begin
            open_clr = 1'b0;
         end
      end
   end

   // Control state: stage valids and open bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         hop_vld_ff <= 1'b0;
         open_ff    <= '0;
      end else if (advance) begin
         s1_vld_ff  <= req_valid;
         hop_vld_ff <= s1_vld_ff;
         if (open_set) begin
            open_ff[s1_idx] <= 1'b1;
         end else if (open_clr) begin
            open_ff[s1_idx] <= 1'b0;
         end
      end
   end

   // Table memory, its registered read, the write bypass and stage payloads.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff  <= req_word;
         ent_rd_ff  <= ent_mem[req_idx];
         byp_hit_ff <= wr_en && (s1_idx == req_idx);
         byp_ent_ff <= wr_ent;
         hop_ff     <= hop_in;
         if (wr_en) begin
            ent_mem[s1_idx] <= wr_ent;
         end
      end
   end

   assign hop_valid = hop_vld_ff;
   assign hop_word  = hop_ff;

endmodule

### rtl/core/cmplt_stats_stage.sv
// ----------------------------------------------------------------------------
// cmplt_stats_stage
// Per-class saturating counters and the registered result word.
// ----------------------------------------------------------------------------
module cmplt_stats_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    hop_valid,
   input  cmplt_pkg::hop_word_type hop_word,
   output logic                    rsp_valid,
   output cmplt_pkg::rsp_word_type rsp_word
);

   logic [cmplt_pkg::COUNT_W-1:0] cnt_ff [cmplt_pkg::NUM_CLASSES];
   logic [cmplt_pkg::TOTAL_W-1:0] tot_ff [cmplt_pkg::NUM_CLASSES];
   logic                          rsp_vld_ff;
   cmplt_pkg::rsp_word_type       rsp_ff;

   logic                          cls_ok;
   logic [cmplt_pkg::COUNT_W-1:0] cnt_cur;
   logic [cmplt_pkg::TOTAL_W-1:0] tot_cur;
   logic [cmplt_pkg::COUNT_W-1:0] cnt_new;
   logic [cmplt_pkg::TOTAL_W:0]   tot_sum;
   logic [cmplt_pkg::TOTAL_W-1:0] tot_new;
   logic                          do_update;
   cmplt_pkg::rsp_word_type       rsp_in;

   assign cls_ok  = hop_word.completed && (hop_word.path_class < cmplt_pkg::CLS_NONE);
   assign cnt_cur = cls_ok ? cnt_ff[hop_word.path_class] : '0;
   assign tot_cur = cls_ok ? tot_ff[hop_word.path_class] : '0;

   // Saturating increment and saturating add of the path latency.
   assign cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + cmplt_pkg::COUNT_W'(1);
   assign tot_sum = {1'b0, tot_cur} +
                    (cmplt_pkg::TOTAL_W + 1)'(hop_word.path_latency);
   assign tot_new = tot_sum[cmplt_pkg::TOTAL_W] ? '1 : tot_sum[cmplt_pkg::TOTAL_W-1:0];

   assign do_update = advance && hop_valid;

   // Result word: all zero unless a path completed.
   always_comb begin
      rsp_in = '0;
      if (cls_ok) begin
         rsp_in.completed        = 1'b1;
         rsp_in.path_class       = hop_word.path_class;
         rsp_in.path_latency     = hop_word.path_latency;
         rsp_in.class_count      = cnt_new;
         rsp_in.class_tick_total = tot_new;
      end
   end

   // Class statistics and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < cmplt_pkg::NUM_CLASSES; i++) begin
            cnt_ff[i] <= '0;
            tot_ff[i] <= '0;
         end
      end else begin
         if (advance) begin
            rsp_vld_ff <= hop_valid;
         end
         if (do_update && hop_word.clear) begin
            for (int i = 0; i < cmplt_pkg::NUM_CLASSES; i++) begin
               cnt_ff[i] <= '0;
               tot_ff[i] <= '0;
            end
         end else if (do_update && cls_ok) begin
            cnt_ff[hop_word.path_class] <= cnt_new;
            tot_ff[hop_word.path_class] <= tot_new;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/core/cache_miss_path_latency_tracker_core.sv
// ----------------------------------------------------------------------------
// cache_miss_path_latency_tracker_core: cache-miss path latency monitor.
// A word passes the entry request register, the hop register and the result register.
// Throughput: one word per cycle; a held result stalls all stages together.
// Reset clears open bits and class statistics; table rows load on open.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cache_miss_path_latency_tracker_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cmplt_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cmplt_pkg::rsp_word_type rsp_word
);

   logic                    advance;
   logic                    hop_valid;
   cmplt_pkg::hop_word_type hop_word;

   // The pipeline moves whenever the result register is free or being taken.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   cmplt_entry_stage u_entry (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_word  (req_word),
      .hop_valid (hop_valid),
      .hop_word  (hop_word)
   );

   cmplt_stats_stage u_stats (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .hop_valid (hop_valid),
      .hop_word  (hop_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // A completed path carries a real class, a nonzero latency and counts it.
   `ASSERT_IMPL(a_done_class, clock, reset, rsp_valid && rsp_word.completed,
      rsp_word.path_class <= cmplt_pkg::CLS_MEM, "completed word with bad class")
   `ASSERT_IMPL(a_done_stats, clock, reset, rsp_valid && rsp_word.completed,
      rsp_word.class_count != '0 && rsp_word.path_latency != '0 &&
      rsp_word.class_tick_total >= 64'(rsp_word.path_latency),
      "completed word with inconsistent statistics")
   `ASSERT_IMPL(a_idle_zero, clock, reset, rsp_valid && !rsp_word.completed,
      rsp_word.path_class == '0 && rsp_word.path_latency == '0 &&
      rsp_word.class_count == '0 && rsp_word.class_tick_total == '0,
      "non-completed word with nonzero fields")

endmodule
